// File: design/eag_pkg.sv
package eag_pkg;

   // Data path and storage sizes.
   localparam int DATA_W    = 32;
   localparam int GPR_COUNT = 8;
   localparam int SEG_COUNT = 6;
   localparam int GPR_AW    = 3;
   localparam int SEG_AW    = 3;

   // Highest segment number that exists.
   localparam logic [SEG_AW-1:0] SEG_LAST = 3'd5;

   // Command codes.
   localparam logic [1:0] CMD_COMPUTE   = 2'd0;
   localparam logic [1:0] CMD_WRITE_GPR = 2'd1;
   localparam logic [1:0] CMD_WRITE_SEG = 2'd2;

   // Operand kinds.
   localparam logic [1:0] KIND_REG_INDIRECT = 2'd0;
   localparam logic [1:0] KIND_DIRECT       = 2'd1;
   localparam logic [1:0] KIND_MODRM_DISP   = 2'd2;
   localparam logic [1:0] KIND_SIB          = 2'd3;

   // ModRM mod encodings.
   localparam logic [1:0] MOD_NO_DISP = 2'd0;
   localparam logic [1:0] MOD_DISP8   = 2'd1;
   localparam logic [1:0] MOD_DISP32  = 2'd2;
   localparam logic [1:0] MOD_REG     = 2'd3;

   // General register numbers in x86 order.
   localparam logic [GPR_AW-1:0] REG_BX = 3'd3;
   localparam logic [GPR_AW-1:0] REG_SP = 3'd4;
   localparam logic [GPR_AW-1:0] REG_BP = 3'd5;
   localparam logic [GPR_AW-1:0] REG_SI = 3'd6;
   localparam logic [GPR_AW-1:0] REG_DI = 3'd7;

   // 32-bit ModRM and SIB special encodings.
   localparam logic [2:0] RM32_SIB    = 3'd4;
   localparam logic [2:0] RM32_DIRECT = 3'd5;
   localparam logic [2:0] SIB_NO_BASE = 3'd5;
   localparam logic [2:0] SIB_NO_IDX  = 3'd4;

   // 16-bit ModRM rm encodings.
   localparam logic [2:0] RM16_BX_SI = 3'd0;
   localparam logic [2:0] RM16_BX_DI = 3'd1;
   localparam logic [2:0] RM16_BP_SI = 3'd2;
   localparam logic [2:0] RM16_BP_DI = 3'd3;
   localparam logic [2:0] RM16_SI    = 3'd4;
   localparam logic [2:0] RM16_DI    = 3'd5;
   localparam logic [2:0] RM16_BP    = 3'd6;
   localparam logic [2:0] RM16_BX    = 3'd7;

   // Request fields as held in the read stage.
   typedef struct packed {
      logic [1:0]        command;
      logic [1:0]        operand_kind;
      logic              addr32;
      logic [1:0]        mod_field;
      logic [2:0]        rm_field;
      logic [1:0]        scale_field;
      logic [2:0]        index_field;
      logic [2:0]        base_field;
      logic [DATA_W-1:0] displacement;
      logic [2:0]        segment;
   } req_type;

   // Outcome of the effective address logic.
   typedef struct packed {
      logic              err;
      logic              addr_ok;
      logic [DATA_W-1:0] ea;
   } calc_type;

endpackage

// File: design/eag_gpr_mem.sv
module eag_gpr_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [eag_pkg::GPR_AW-1:0]  rd_addr_a,
   input  logic [eag_pkg::GPR_AW-1:0]  rd_addr_b,
   output logic [eag_pkg::DATA_W-1:0]  rd_data_a,
   output logic [eag_pkg::DATA_W-1:0]  rd_data_b,
   input  logic                        wr_en,
   input  logic [eag_pkg::GPR_AW-1:0]  wr_addr,
   input  logic [eag_pkg::DATA_W-1:0]  wr_data
);
   import eag_pkg::*;

   logic [DATA_W-1:0]    mem_ff [GPR_COUNT];
   logic [GPR_COUNT-1:0] vld_ff;
   logic [GPR_COUNT-1:0] vld_in;
   logic [DATA_W-1:0]    rd_a_ff;
   logic [DATA_W-1:0]    rd_b_ff;
   logic                 rd_a_vld_ff;
   logic                 rd_b_vld_ff;

   // An entry reads as zero until it has been written once after reset.
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Two registered read ports.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff     <= mem_ff[rd_addr_a];
         rd_b_ff     <= mem_ff[rd_addr_b];
         rd_a_vld_ff <= vld_ff[rd_addr_a];
         rd_b_vld_ff <= vld_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_vld_ff ? rd_a_ff : '0;
   assign rd_data_b = rd_b_vld_ff ? rd_b_ff : '0;

endmodule

// File: design/eag_seg_mem.sv
module eag_seg_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [eag_pkg::SEG_AW-1:0]  rd_addr,
   output logic [eag_pkg::DATA_W-1:0]  rd_data,
   input  logic                        wr_en,
   input  logic [eag_pkg::SEG_AW-1:0]  wr_addr,
   input  logic [eag_pkg::DATA_W-1:0]  wr_data
);
   import eag_pkg::*;

   logic [DATA_W-1:0]    mem_ff [SEG_COUNT];
   logic [SEG_COUNT-1:0] vld_ff;
   logic [SEG_COUNT-1:0] vld_in;
   logic [DATA_W-1:0]    rd_ff;
   logic                 rd_vld_ff;

   // Writes beyond the last segment are dropped.
   always_comb begin
      vld_in = vld_ff;
      if (wr_en && (wr_addr <= SEG_LAST)) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr <= SEG_LAST)) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; a nonexistent segment reads as zero.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (rd_addr <= SEG_LAST) begin
            rd_ff     <= mem_ff[rd_addr];
            rd_vld_ff <= vld_ff[rd_addr];
         end else begin
            rd_ff     <= '0;
            rd_vld_ff <= 1'b0;
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_ff : '0;

endmodule

// File: design/eag_ea_calc.sv
module eag_ea_calc (
   input  eag_pkg::req_type            req,
   input  logic [eag_pkg::DATA_W-1:0]  gpr_a,
   input  logic [eag_pkg::DATA_W-1:0]  gpr_b,
   output eag_pkg::calc_type           calc
);
   import eag_pkg::*;

   logic [DATA_W-1:0] disp8;
   logic [DATA_W-1:0] disp_sel;
   logic [DATA_W-1:0] a16;
   logic [DATA_W-1:0] b16;
   logic [DATA_W-1:0] term_a;
   logic [DATA_W-1:0] term_b;
   logic [DATA_W-1:0] term_d;
   logic [DATA_W-1:0] sum;
   logic              ea_valid;
   logic              use_a16;
   logic              use_b16;

   // Displacement as selected by mod: disp8 is sign extended.
   assign disp8    = {{(DATA_W-8){req.displacement[7]}}, req.displacement[7:0]};
   assign disp_sel = (req.mod_field == MOD_DISP8) ? disp8 : req.displacement;

   // In 16-bit mode port A holds BX or BP and port B holds SI or DI.
   assign use_a16 = (req.rm_field != RM16_SI) && (req.rm_field != RM16_DI);
   assign use_b16 = (req.rm_field != RM16_BP) && (req.rm_field != RM16_BX);
   assign a16 = use_a16 ? {{(DATA_W-16){1'b0}}, gpr_a[15:0]} : '0;
   assign b16 = use_b16 ? {{(DATA_W-16){1'b0}}, gpr_b[15:0]} : '0;

   // Pick the three addends and check the encoding.
   always_comb begin
      term_a   = '0;
      term_b   = '0;
      term_d   = '0;
      ea_valid = 1'b1;
      case (req.operand_kind)
         KIND_REG_INDIRECT: begin
            if (req.addr32) begin
               if ((req.rm_field == REG_SP) || (req.rm_field == REG_BP)) begin
                  ea_valid = 1'b0;
               end
               term_a = gpr_a;
            end else begin
               if (req.rm_field == RM16_BP) begin
                  ea_valid = 1'b0;
               end
               term_a = a16;
               term_b = b16;
            end
         end
         KIND_DIRECT: begin
            term_d = req.displacement;
         end
         KIND_MODRM_DISP: begin
            if (req.mod_field == MOD_REG) begin
               ea_valid = 1'b0;
            end else if (req.mod_field == MOD_NO_DISP) begin
               if (req.addr32 ? (req.rm_field != RM32_DIRECT)
                              : (req.rm_field != RM16_BP)) begin
                  ea_valid = 1'b0;
               end
               term_d = req.displacement;
            end else begin
               if (req.addr32) begin
                  if (req.rm_field == RM32_SIB) begin
                     ea_valid = 1'b0;
                  end
                  term_a = gpr_a;
               end else begin
                  term_a = a16;
                  term_b = b16;
               end
               term_d = disp_sel;
            end
         end
         KIND_SIB: begin
            if (!req.addr32 || (req.mod_field == MOD_REG) || (req.rm_field != RM32_SIB)) begin
               ea_valid = 1'b0;
            end
            if (req.index_field != SIB_NO_IDX) begin
               term_b = gpr_b << req.scale_field;
            end
            if ((req.base_field == SIB_NO_BASE) && (req.mod_field == MOD_NO_DISP)) begin
               term_d = req.displacement;
            end else begin
               term_a = gpr_a;
               if (req.mod_field != MOD_NO_DISP) begin
                  term_d = disp_sel;
               end
            end
         end
         default: begin
            ea_valid = 1'b0;
         end
      endcase
   end

   // One three-operand add; 16-bit mode wraps and zero extends.
   assign sum = term_a + term_b + term_d;

   always_comb begin
      calc.ea      = req.addr32 ? sum : {{(DATA_W-16){1'b0}}, sum[15:0]};
      calc.err     = 1'b1;
      calc.addr_ok = 1'b0;
      case (req.command)
         CMD_COMPUTE: begin
            calc.err     = !ea_valid || (req.segment > SEG_LAST);
            calc.addr_ok = !calc.err;
         end
         CMD_WRITE_GPR: begin
            calc.err = 1'b0;
         end
         CMD_WRITE_SEG: begin
            calc.err = (req.rm_field > SEG_LAST);
         end
         default: begin
            calc.err = 1'b1;
         end
      endcase
   end

endmodule

// File: design/x86_effective_address_generator_top.sv
// x86 effective address generator. The block holds the eight general registers and six
// segment bases in small synchronous register files and turns each compute request into
// segment base plus ModRM/SIB effective address, with 16-bit wrap in 16-bit addressing;
// write commands load a register file and answer with address zero. It takes one request
// per clock while req_stall is low and returns one result per request in order. A request
// passes through the register file read, the effective address add and the segment base
// add, each registered. A register write is seen by the request right behind it, since
// the write lands before that request's read. Both register files read as zero after
// reset, and no clearing pass is needed.
module x86_effective_address_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [1:0]  req_operand_kind,
   input  logic        req_addr32,
   input  logic [1:0]  req_mod_field,
   input  logic [2:0]  req_rm_field,
   input  logic [1:0]  req_scale_field,
   input  logic [2:0]  req_index_field,
   input  logic [2:0]  req_base_field,
   input  logic [31:0] req_displacement,
   input  logic [2:0]  req_segment,
   input  logic [31:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_linear_address,
   output logic        rsp_error_code
);
   import eag_pkg::*;

   logic              accept;
   logic              out_free;
   logic              s2_free;
   logic              s1_free;
   logic [GPR_AW-1:0] rd_addr_a;
   logic [GPR_AW-1:0] rd_addr_b;
   logic [DATA_W-1:0] gpr_a;
   logic [DATA_W-1:0] gpr_b;
   logic [DATA_W-1:0] seg_base;
   calc_type          calc;

   req_type           s1_req_ff;
   req_type           s1_req_in;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s2_valid_ff;
   logic              s2_valid_in;
   logic [DATA_W-1:0] s2_ea_ff;
   logic [DATA_W-1:0] s2_ea_in;
   logic [DATA_W-1:0] s2_base_ff;
   logic [DATA_W-1:0] s2_base_in;
   logic              s2_err_ff;
   logic              s2_err_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [DATA_W-1:0] rsp_addr_ff;
   logic [DATA_W-1:0] rsp_addr_in;
   logic              rsp_err_ff;
   logic              rsp_err_in;

   // Each stage moves on when the stage after it is empty or draining.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   // Register file read addresses; 16-bit mode uses port A for BX or BP and
   // port B for SI or DI.
   always_comb begin
      if (req_addr32) begin
         rd_addr_a = (req_operand_kind == KIND_SIB) ? req_base_field : req_rm_field;
         rd_addr_b = req_index_field;
      end else begin
         case (req_rm_field)
            RM16_BP_SI, RM16_BP_DI, RM16_BP: rd_addr_a = REG_BP;
            default:                         rd_addr_a = REG_BX;
         endcase
         case (req_rm_field)
            RM16_BX_DI, RM16_BP_DI, RM16_DI: rd_addr_b = REG_DI;
            default:                         rd_addr_b = REG_SI;
         endcase
      end
   end

   // Register files: writes land at the transfer, reads are registered.
   eag_gpr_mem u_gpr_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (gpr_a),
      .rd_data_b (gpr_b),
      .wr_en     (accept && (req_command == CMD_WRITE_GPR)),
      .wr_addr   (req_rm_field),
      .wr_data   (req_write_value)
   );

   eag_seg_mem u_seg_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_segment),
      .rd_data (seg_base),
      .wr_en   (accept && (req_command == CMD_WRITE_SEG)),
      .wr_addr (req_rm_field),
      .wr_data (req_write_value)
   );

   // Read stage: request fields travel beside the register file reads.
   always_comb begin
      s1_req_in.command      = req_command;
      s1_req_in.operand_kind = req_operand_kind;
      s1_req_in.addr32       = req_addr32;
      s1_req_in.mod_field    = req_mod_field;
      s1_req_in.rm_field     = req_rm_field;
      s1_req_in.scale_field  = req_scale_field;
      s1_req_in.index_field  = req_index_field;
      s1_req_in.base_field   = req_base_field;
      s1_req_in.displacement = req_displacement;
      s1_req_in.segment      = req_segment;
      s1_valid_in            = s1_free ? req_valid : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= s1_req_in;
      end
   end

   eag_ea_calc u_ea_calc (
      .req   (s1_req_ff),
      .gpr_a (gpr_a),
      .gpr_b (gpr_b),
      .calc  (calc)
   );

   // Address stage: writes and errors carry zero addends.
   always_comb begin
      s2_ea_in    = calc.addr_ok ? calc.ea : '0;
      s2_base_in  = calc.addr_ok ? seg_base : '0;
      s2_err_in   = calc.err;
      s2_valid_in = s2_free ? s1_valid_ff : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid_ff) begin
         s2_ea_ff   <= s2_ea_in;
         s2_base_ff <= s2_base_in;
         s2_err_ff  <= s2_err_in;
      end
   end

   // Output stage: segment base add.
   always_comb begin
      rsp_addr_in  = s2_ea_ff + s2_base_ff;
      rsp_err_in   = s2_err_ff;
      rsp_valid_in = out_free ? s2_valid_ff : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_valid_ff) begin
         rsp_addr_ff <= rsp_addr_in;
         rsp_err_ff  <= rsp_err_in;
      end
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_linear_address = rsp_addr_ff;
   assign rsp_error_code     = rsp_err_ff;

endmodule
